// File: rtl/lrb_pkg.sv
// Package for the link recovery backoff controller: register indexes, state codes,
// field widths, reset values and the result item layout.
// No dependencies.
package lrb_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_TRY_DURATION     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RETRY_INTERVAL   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SLEEP_DURATION   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ATTEMPT_DURATION = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_UP_BLINK_PERIOD  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_UP_BLINK_ON      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TRY_BLINK_PERIOD = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_TRY_BLINK_ON     = 3'd7;

   // register widths
   localparam int DUR_W   = 24;
   localparam int BLINK_W = 16;

   // reset values of the registers
   localparam logic [DUR_W-1:0]   RST_TRY_DURATION     = 24'd60000;
   localparam logic [DUR_W-1:0]   RST_RETRY_INTERVAL   = 24'd10000;
   localparam logic [DUR_W-1:0]   RST_SLEEP_DURATION   = 24'd120000;
   localparam logic [DUR_W-1:0]   RST_ATTEMPT_DURATION = 24'd10000;
   localparam logic [BLINK_W-1:0] RST_UP_BLINK_PERIOD  = 16'd3000;
   localparam logic [BLINK_W-1:0] RST_UP_BLINK_ON      = 16'd2900;
   localparam logic [BLINK_W-1:0] RST_TRY_BLINK_PERIOD = 16'd200;
   localparam logic [BLINK_W-1:0] RST_TRY_BLINK_ON     = 16'd100;

   // sensor adjustment period, ticks
   localparam logic [BLINK_W-1:0] ADJUST_PERIOD = 16'd60000;

   // default width of the state and retry timers
   localparam int TIMER_WIDTH_DEF = 24;

   // recovery state codes
   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] ST_TRYING     = 2'd0;
   localparam logic [STATE_W-1:0] ST_SLEEPING   = 2'd1;
   localparam logic [STATE_W-1:0] ST_ATTEMPTING = 2'd2;
   localparam logic [STATE_W-1:0] ST_UNUSED     = 2'd3;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // result item, first member in the highest bits of the struct
   typedef struct packed {
      logic               adjust_pulse;
      logic               server_stop_pulse;
      logic               server_start_pulse;
      logic               radio_wake_pulse;
      logic               radio_off_pulse;
      logic               retry_pulse;
      logic [STATE_W-1:0] recovery_state;
      logic               led_on;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

// File: rtl/link_recovery_backoff_controller.sv
// Link recovery backoff controller, top level.
// Depends on lrb_pkg.
//
// Usage:
//   req_ channel: one item per millisecond tick, req_tdata[0] = link_up.
//   rsp_ channel: exactly one result item per tick item, in order.
//   csr_ port: csr_we writes csr_wdata into register csr_addr at the clock
//     edge; indexes 0..7 are try_duration, retry_interval, sleep_duration,
//     attempt_duration, up_blink_period, up_blink_on, try_blink_period and
//     try_blink_on. Write only while no item is in flight.
// Pipeline: a taken item shows on rsp_tvalid once it has passed one input
//   register and then one result register.
// Throughput: one item per cycle while rsp_tready stays high; the recovery
//   logic between the input and result registers is a handful of counter
//   compares.
// Reset (synchronous, active high): registers return to their defaults, the
//   machine to trying, the retry timer to its saturated maximum, the other
//   timers to zero, and both stages empty.
// Receiver stall: the result register holds its item; the input register
//   still takes one more item, then req_tready drops until rsp_tready returns.
module link_recovery_backoff_controller #(
   parameter int TIMER_WIDTH = lrb_pkg::TIMER_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lrb_pkg::REQ_DATA_W-1:0]   req_tdata,  // [0] link_up, [7:1] zero
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] led_on, [2:1] recovery_state, [3] retry_pulse, [4] radio_off_pulse,
   // [5] radio_wake_pulse, [6] server_start_pulse, [7] server_stop_pulse,
   // [8] adjust_pulse, [15:9] zero
   output logic [lrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write port
   input  logic                             csr_we,
   input  logic [lrb_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lrb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DUR_W   = lrb_pkg::DUR_W;
   localparam int BLINK_W = lrb_pkg::BLINK_W;
   localparam int STATE_W = lrb_pkg::STATE_W;
   // compare width covers both the timer and the 24-bit duration registers
   localparam int CMP_W   = (TIMER_WIDTH > DUR_W) ? TIMER_WIDTH : DUR_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DUR_W-1:0]   try_duration_ff, retry_interval_ff;
   logic [DUR_W-1:0]   sleep_duration_ff, attempt_duration_ff;
   logic [BLINK_W-1:0] up_blink_period_ff, up_blink_on_ff;
   logic [BLINK_W-1:0] try_blink_period_ff, try_blink_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         try_duration_ff     <= lrb_pkg::RST_TRY_DURATION;
         retry_interval_ff   <= lrb_pkg::RST_RETRY_INTERVAL;
         sleep_duration_ff   <= lrb_pkg::RST_SLEEP_DURATION;
         attempt_duration_ff <= lrb_pkg::RST_ATTEMPT_DURATION;
         up_blink_period_ff  <= lrb_pkg::RST_UP_BLINK_PERIOD;
         up_blink_on_ff      <= lrb_pkg::RST_UP_BLINK_ON;
         try_blink_period_ff <= lrb_pkg::RST_TRY_BLINK_PERIOD;
         try_blink_on_ff     <= lrb_pkg::RST_TRY_BLINK_ON;
      end else if (csr_we) begin
         case (csr_addr)
            lrb_pkg::REG_TRY_DURATION:     try_duration_ff     <= csr_wdata;
            lrb_pkg::REG_RETRY_INTERVAL:   retry_interval_ff   <= csr_wdata;
            lrb_pkg::REG_SLEEP_DURATION:   sleep_duration_ff   <= csr_wdata;
            lrb_pkg::REG_ATTEMPT_DURATION: attempt_duration_ff <= csr_wdata;
            lrb_pkg::REG_UP_BLINK_PERIOD:  up_blink_period_ff  <= csr_wdata[BLINK_W-1:0];
            lrb_pkg::REG_UP_BLINK_ON:      up_blink_on_ff      <= csr_wdata[BLINK_W-1:0];
            lrb_pkg::REG_TRY_BLINK_PERIOD: try_blink_period_ff <= csr_wdata[BLINK_W-1:0];
            lrb_pkg::REG_TRY_BLINK_ON:     try_blink_on_ff     <= csr_wdata[BLINK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: input register, then result register
   // ---------------------------------------------------------------------
   logic in_valid_ff, in_link_ff;
   logic rsp_valid_ff;
   lrb_pkg::result_type rsp_data_ff, rsp_data_in;
   logic advance;   // the input register moves into the result register

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lrb_pkg::RSP_DATA_W - lrb_pkg::RESULT_W){1'b0}}, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_link_ff <= req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Recovery state and timers
   // ---------------------------------------------------------------------
   logic [STATE_W-1:0]     mode_state_ff, mode_state_in;
   logic [TIMER_WIDTH-1:0] mode_timer_ff, mode_timer_in;
   logic [TIMER_WIDTH-1:0] retry_timer_ff, retry_timer_in;
   logic [BLINK_W-1:0]     blink_timer_ff, blink_timer_in;
   logic [BLINK_W-1:0]     adjust_timer_ff, adjust_timer_in;
   logic                   service_running_ff, service_running_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_state_ff      <= lrb_pkg::ST_TRYING;
         mode_timer_ff      <= '0;
         retry_timer_ff     <= '1;
         blink_timer_ff     <= '0;
         adjust_timer_ff    <= '0;
         service_running_ff <= 1'b0;
      end else if (advance) begin
         mode_state_ff      <= mode_state_in;
         mode_timer_ff      <= mode_timer_in;
         retry_timer_ff     <= retry_timer_in;
         blink_timer_ff     <= blink_timer_in;
         adjust_timer_ff    <= adjust_timer_in;
         service_running_ff <= service_running_in;
      end
   end

   // threshold checks, timers widened to cover the duration registers
   logic [CMP_W-1:0] mode_cmp, retry_cmp;
   logic             try_done, sleep_done, attempt_done, retry_due;
   logic             up_lit, up_wrap, try_lit, try_wrap, adjust_due;

   assign mode_cmp     = CMP_W'(mode_timer_ff);
   assign retry_cmp    = CMP_W'(retry_timer_ff);
   assign try_done     = mode_cmp  >= CMP_W'(try_duration_ff);
   assign sleep_done   = mode_cmp  >= CMP_W'(sleep_duration_ff);
   assign attempt_done = mode_cmp  >= CMP_W'(attempt_duration_ff);
   assign retry_due    = retry_cmp >= CMP_W'(retry_interval_ff);
   assign up_lit       = blink_timer_ff >= up_blink_on_ff;
   assign up_wrap      = blink_timer_ff >= up_blink_period_ff;
   assign try_lit      = blink_timer_ff >= try_blink_on_ff;
   assign try_wrap     = blink_timer_ff >= try_blink_period_ff;
   assign adjust_due   = adjust_timer_ff >= lrb_pkg::ADJUST_PERIOD;

   always_comb begin
      logic [STATE_W-1:0] st;
      logic               blink_restart, retry_restart, mode_restart, adjust_restart;

      rsp_data_in        = '0;
      blink_restart      = 1'b0;
      retry_restart      = 1'b0;
      mode_restart       = 1'b0;
      adjust_restart     = 1'b0;
      service_running_in = service_running_ff;

      // the unused code behaves as trying
      st = (mode_state_ff == lrb_pkg::ST_UNUSED) ? lrb_pkg::ST_TRYING : mode_state_ff;

      // LED from the state held before this tick
      if (in_link_ff) begin
         rsp_data_in.led_on = up_lit;
         blink_restart      = up_wrap;
      end else if (st == lrb_pkg::ST_TRYING) begin
         rsp_data_in.led_on = try_lit;
         blink_restart      = try_wrap;
      end else if (st == lrb_pkg::ST_ATTEMPTING) begin
         rsp_data_in.led_on = 1'b1;
      end

      if (in_link_ff) begin
         st = lrb_pkg::ST_TRYING;
         if (!service_running_ff) begin
            rsp_data_in.server_start_pulse = 1'b1;
            service_running_in             = 1'b1;
         end
         if (adjust_due) begin
            rsp_data_in.adjust_pulse = 1'b1;
            adjust_restart           = 1'b1;
         end
      end else begin
         if (service_running_ff) begin
            rsp_data_in.server_stop_pulse = 1'b1;
            service_running_in            = 1'b0;
         end
         case (st)
            lrb_pkg::ST_SLEEPING: begin
               if (sleep_done) begin
                  rsp_data_in.radio_wake_pulse = 1'b1;
                  st                           = lrb_pkg::ST_ATTEMPTING;
                  mode_restart                 = 1'b1;
               end
            end
            lrb_pkg::ST_ATTEMPTING: begin
               if (attempt_done) begin
                  rsp_data_in.radio_off_pulse = 1'b1;
                  st                          = lrb_pkg::ST_SLEEPING;
                  mode_restart                = 1'b1;
               end
            end
            default: begin
               // trying: retry and radio-off may fire together
               if (retry_due) begin
                  rsp_data_in.retry_pulse = 1'b1;
                  retry_restart           = 1'b1;
               end
               if (try_done) begin
                  rsp_data_in.radio_off_pulse = 1'b1;
                  st                          = lrb_pkg::ST_SLEEPING;
                  mode_restart                = 1'b1;
               end
            end
         endcase
      end

      rsp_data_in.recovery_state = st;
      mode_state_in              = st;

      // saturating advance; a restart makes the next tick see one
      if (in_link_ff) begin
         mode_timer_in = '0;
      end else if (mode_restart) begin
         mode_timer_in = TIMER_WIDTH'(1);
      end else begin
         mode_timer_in = (&mode_timer_ff) ? mode_timer_ff : mode_timer_ff + 1'b1;
      end
      if (retry_restart) begin
         retry_timer_in = TIMER_WIDTH'(1);
      end else begin
         retry_timer_in = (&retry_timer_ff) ? retry_timer_ff : retry_timer_ff + 1'b1;
      end
      if (blink_restart) begin
         blink_timer_in = BLINK_W'(1);
      end else begin
         blink_timer_in = (&blink_timer_ff) ? blink_timer_ff : blink_timer_ff + 1'b1;
      end
      if (adjust_restart) begin
         adjust_timer_in = BLINK_W'(1);
      end else begin
         adjust_timer_in = (&adjust_timer_ff) ? adjust_timer_ff : adjust_timer_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // the machine never enters the unused code
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      mode_state_ff != lrb_pkg::ST_UNUSED)
      else $error("recovery state holds the unused code");

   // a wake always lands in attempting
   a_wake_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.radio_wake_pulse) |->
         rsp_data_ff.recovery_state == lrb_pkg::ST_ATTEMPTING)
      else $error("wake pulse outside attempting");

   // link-up events never mix with recovery events
   a_up_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.server_start_pulse || rsp_data_ff.adjust_pulse)) |->
         (!rsp_data_ff.retry_pulse && !rsp_data_ff.radio_off_pulse &&
          !rsp_data_ff.radio_wake_pulse && !rsp_data_ff.server_stop_pulse &&
          rsp_data_ff.recovery_state == lrb_pkg::ST_TRYING))
      else $error("link-up pulse together with a recovery pulse");

   // a result taken without a new one leaves the result register empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !advance) |=> !rsp_valid_ff)
      else $error("result register did not drain");

   // the service flag follows the link of the last processed item
   a_service: assert property (@(posedge clock) disable iff (reset)
      advance |=> (service_running_ff == $past(in_link_ff)))
      else $error("service flag out of step with the link");

endmodule
